// ===== src/sit_pkg.sv =====
// Shared types, codes and default sizes for the sorted interval table.
`timescale 1ns / 1ps

package sit_pkg;

    localparam int SIT_CAPACITY  = 256;
    localparam int SIT_TAG_WIDTH = 32;
    localparam int SIT_IN_BITS   = 112;
    localparam int SIT_OUT_BITS  = 120;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_GET    = 3'd2;
    localparam logic [2:0] MODE_FIND   = 3'd3;
    localparam logic [2:0] MODE_SPLIT  = 3'd4;
    localparam logic [2:0] MODE_RANGE  = 3'd5;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_ZERO_LEN  = 4'd1;
    localparam logic [3:0] ST_WRAPS     = 4'd2;
    localparam logic [3:0] ST_OVERLAP   = 4'd3;
    localparam logic [3:0] ST_FULL      = 4'd4;
    localparam logic [3:0] ST_BAD_SLOT  = 4'd5;
    localparam logic [3:0] ST_OUTSIDE   = 4'd6;
    localparam logic [3:0] ST_GAP       = 4'd7;
    localparam logic [3:0] ST_BAD_SPLIT = 4'd8;
    localparam logic [3:0] ST_NOT_CONTIG = 4'd9;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

    typedef enum logic [1:0] {
        PS_DELAY1,
        PS_BYPASS,
        PS_DELAY2
    } push_sel_t;

endpackage

// ===== src/sit_cell.sv =====
// One storage cell of the interval chain: holds one entry and passes it on.
`timescale 1ns / 1ps

module sit_cell #(
    parameter int TAG_WIDTH = sit_pkg::SIT_TAG_WIDTH
) (
    input  logic                 aclk,
    input  logic                 shift_en,
    input  logic [31:0]          din_start,
    input  logic [31:0]          din_length,
    input  logic [TAG_WIDTH-1:0] din_tag,
    output logic [31:0]          start_reg,
    output logic [31:0]          length_reg,
    output logic [TAG_WIDTH-1:0] tag_reg
);

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            start_reg  <= din_start;
            length_reg <= din_length;
            tag_reg    <= din_tag;
        end
    end

endmodule

// ===== src/sit_ctrl.sv =====
// Request controller: scans the rotating chain, edits it in flight and builds replies.
`timescale 1ns / 1ps

module sit_ctrl #(
    parameter int CAPACITY  = sit_pkg::SIT_CAPACITY,
    parameter int TAG_WIDTH = sit_pkg::SIT_TAG_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sit_pkg::SIT_IN_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sit_pkg::SIT_OUT_BITS-1:0] m_tdata,
    output logic                          shift_en,
    output logic [31:0]                   push_start,
    output logic [31:0]                   push_length,
    output logic [TAG_WIDTH-1:0]          push_tag,
    input  logic [31:0]                   tail_start,
    input  logic [31:0]                   tail_length,
    input  logic [TAG_WIDTH-1:0]          tail_tag
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = (SW > 8) ? SW : 8;
    localparam logic [SW-1:0] CAP_W = SW'(CAPACITY);

    sit_pkg::fsm_state_t state_reg, state_next;
    sit_pkg::push_sel_t  psel_reg, psel_next;

    logic [2:0]           mode_reg, mode_next;
    logic [31:0]          off_reg, off_next;
    logic [31:0]          len_reg, len_next;
    logic [7:0]           slot_reg, slot_next;
    logic [32:0]          end_reg, end_next;
    logic [32:0]          lastpt_reg, lastpt_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [SW-1:0]        count_reg, count_next;
    logic [3:0]           st_reg, st_next;
    logic                 found_reg, found_next;
    logic                 ins_arm_reg, ins_arm_next;
    logic [SW-1:0]        ins_step_reg, ins_step_next;
    logic [31:0]          new_start_reg, new_start_next;
    logic [31:0]          new_len_reg, new_len_next;
    logic [TAG_WIDTH-1:0] new_tag_reg, new_tag_next;
    logic [31:0]          b_start_reg, b_start_next;
    logic [31:0]          b_len_reg, b_len_next;
    logic [TAG_WIDTH-1:0] b_tag_reg, b_tag_next;
    logic [31:0]          b2_start_reg, b2_start_next;
    logic [31:0]          b2_len_reg, b2_len_next;
    logic [TAG_WIDTH-1:0] b2_tag_reg, b2_tag_next;
    logic [31:0]          hit_start_reg, hit_start_next;
    logic [31:0]          hit_len_reg, hit_len_next;
    logic [TAG_WIDTH-1:0] hit_tag_reg, hit_tag_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 pa_valid_reg, pa_valid_next;
    logic [32:0]          pa_end_reg, pa_end_next;
    logic                 pb_valid_reg, pb_valid_next;
    logic [32:0]          pb_end_reg, pb_end_next;
    logic [32:0]          last_end_reg, last_end_next;
    logic                 brk_reg, brk_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [sit_pkg::SIT_OUT_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic        out_load;
    logic [32:0] t_end, b_end;
    logic        held, do_ins, slot_hit, full;
    logic [3:0]  look_a, look_b, fin_st;
    logic        fin_entry;
    logic [31:0] in_off, in_len;

    assign in_off = s_tdata[34:3];
    assign in_len = s_tdata[66:35];
    assign t_end    = {1'b0, tail_start} + {1'b0, tail_length};
    assign b_end    = {1'b0, b_start_reg} + {1'b0, b_len_reg};
    assign held     = step_reg < count_reg;
    assign do_ins   = ins_arm_reg && (step_reg == ins_step_reg);
    assign slot_hit = IW'(step_reg) == IW'(slot_reg);
    assign full     = count_reg >= CAP_W;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sit_pkg::FSM_IDLE: if (s_tvalid) state_next = sit_pkg::FSM_SCAN;
            sit_pkg::FSM_SCAN: if (step_reg == CAP_W) state_next = sit_pkg::FSM_DONE;
            sit_pkg::FSM_DONE: if (out_load) state_next = sit_pkg::FSM_IDLE;
            default:           state_next = sit_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready = state_reg == sit_pkg::FSM_IDLE;
        shift_en = state_reg == sit_pkg::FSM_SCAN;
        out_load = (state_reg == sit_pkg::FSM_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        if (!pa_valid_reg || ({1'b0, off_reg} > last_end_reg)) begin
            look_a = sit_pkg::ST_OUTSIDE;
        end else if ({1'b0, off_reg} < pa_end_reg) begin
            look_a = sit_pkg::ST_OK;
        end else begin
            look_a = sit_pkg::ST_GAP;
        end
        if (!pb_valid_reg || (lastpt_reg > last_end_reg)) begin
            look_b = sit_pkg::ST_OUTSIDE;
        end else if (lastpt_reg < pb_end_reg) begin
            look_b = sit_pkg::ST_OK;
        end else begin
            look_b = sit_pkg::ST_GAP;
        end
        fin_st = st_reg;
        if (mode_reg == sit_pkg::MODE_FIND) begin
            fin_st = look_a;
        end else if (mode_reg == sit_pkg::MODE_RANGE && st_reg == sit_pkg::ST_OK) begin
            if (look_a != sit_pkg::ST_OK) begin
                fin_st = look_a;
            end else if (look_b != sit_pkg::ST_OK) begin
                fin_st = look_b;
            end else if (brk_reg) begin
                fin_st = sit_pkg::ST_NOT_CONTIG;
            end
        end
        fin_entry = (fin_st == sit_pkg::ST_OK) && (mode_reg <= sit_pkg::MODE_RANGE);
    end

    always_comb begin
        psel_next      = psel_reg;
        mode_next      = mode_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        slot_next      = slot_reg;
        end_next       = end_reg;
        lastpt_next    = lastpt_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        found_next     = found_reg;
        ins_arm_next   = ins_arm_reg;
        ins_step_next  = ins_step_reg;
        new_start_next = new_start_reg;
        new_len_next   = new_len_reg;
        new_tag_next   = new_tag_reg;
        b_start_next   = b_start_reg;
        b_len_next     = b_len_reg;
        b_tag_next     = b_tag_reg;
        b2_start_next  = b2_start_reg;
        b2_len_next    = b2_len_reg;
        b2_tag_next    = b2_tag_reg;
        hit_start_next = hit_start_reg;
        hit_len_next   = hit_len_reg;
        hit_tag_next   = hit_tag_reg;
        hit_idx_next   = hit_idx_reg;
        pa_valid_next  = pa_valid_reg;
        pa_end_next    = pa_end_reg;
        pb_valid_next  = pb_valid_reg;
        pb_end_next    = pb_end_reg;
        last_end_next  = last_end_reg;
        brk_next       = brk_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        push_start     = b_start_reg;
        push_length    = b_len_reg;
        push_tag       = b_tag_reg;

        unique case (state_reg)
            sit_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    mode_next      = s_tdata[2:0];
                    off_next       = in_off;
                    len_next       = in_len;
                    slot_next      = s_tdata[74:67];
                    new_start_next = in_off;
                    new_len_next   = in_len;
                    new_tag_next   = TAG_WIDTH'(s_tdata[106:75]);
                    end_next       = {1'b0, in_off} + {1'b0, in_len};
                    lastpt_next    = {1'b0, in_off} + {1'b0, in_len}
                                     - ((in_len == 32'd0) ? 33'd0 : 33'd1);
                    step_next      = '0;
                    psel_next      = sit_pkg::PS_DELAY1;
                    found_next     = 1'b0;
                    ins_arm_next   = 1'b0;
                    pa_valid_next  = 1'b0;
                    pb_valid_next  = 1'b0;
                    brk_next       = 1'b0;
                    st_next        = sit_pkg::ST_OK;
                    unique case (s_tdata[2:0])
                        sit_pkg::MODE_ADD: begin
                            if (in_len == 32'd0) begin
                                st_next = sit_pkg::ST_ZERO_LEN;
                            end else if (end_next[32]) begin
                                st_next = sit_pkg::ST_WRAPS;
                            end
                        end
                        sit_pkg::MODE_REMOVE, sit_pkg::MODE_GET, sit_pkg::MODE_SPLIT: begin
                            if (IW'(s_tdata[74:67]) >= IW'(count_reg)) begin
                                st_next = sit_pkg::ST_BAD_SLOT;
                            end
                        end
                        sit_pkg::MODE_RANGE: begin
                            if (lastpt_next[32]) st_next = sit_pkg::ST_OUTSIDE;
                        end
                        default: st_next = sit_pkg::ST_OK;
                    endcase
                end
            end

            sit_pkg::FSM_SCAN: begin
                step_next = step_reg + SW'(1);
                if (do_ins) begin
                    push_start    = new_start_reg;
                    push_length   = new_len_reg;
                    push_tag      = new_tag_reg;
                    b2_start_next = b_start_reg;
                    b2_len_next   = b_len_reg;
                    b2_tag_next   = b_tag_reg;
                    b_start_next  = tail_start;
                    b_len_next    = tail_length;
                    b_tag_next    = tail_tag;
                    psel_next     = sit_pkg::PS_DELAY2;
                    ins_arm_next  = 1'b0;
                end else begin
                    unique case (psel_reg)
                        sit_pkg::PS_BYPASS: begin
                            push_start  = tail_start;
                            push_length = tail_length;
                            push_tag    = tail_tag;
                        end
                        sit_pkg::PS_DELAY2: begin
                            push_start    = b2_start_reg;
                            push_length   = b2_len_reg;
                            push_tag      = b2_tag_reg;
                            b2_start_next = b_start_reg;
                            b2_len_next   = b_len_reg;
                            b2_tag_next   = b_tag_reg;
                            b_start_next  = tail_start;
                            b_len_next    = tail_length;
                            b_tag_next    = tail_tag;
                        end
                        default: begin
                            b_start_next = tail_start;
                            b_len_next   = tail_length;
                            b_tag_next   = tail_tag;
                        end
                    endcase
                end

                unique case (mode_reg)
                    sit_pkg::MODE_ADD: begin
                        if (!found_reg && (!held || tail_start > off_reg)) begin
                            found_next = 1'b1;
                            if (st_reg == sit_pkg::ST_OK) begin
                                if ((step_reg != '0 && {1'b0, off_reg} < b_end) ||
                                    (held && end_reg > {1'b0, tail_start})) begin
                                    st_next = sit_pkg::ST_OVERLAP;
                                end else if (full) begin
                                    st_next = sit_pkg::ST_FULL;
                                end else begin
                                    ins_arm_next   = 1'b1;
                                    ins_step_next  = step_reg + SW'(1);
                                    hit_start_next = off_reg;
                                    hit_len_next   = len_reg;
                                    hit_tag_next   = new_tag_reg;
                                    hit_idx_next   = IW'(step_reg);
                                end
                            end
                        end
                    end
                    sit_pkg::MODE_REMOVE, sit_pkg::MODE_GET: begin
                        if (st_reg == sit_pkg::ST_OK && slot_hit) begin
                            hit_start_next = tail_start;
                            hit_len_next   = tail_length;
                            hit_tag_next   = tail_tag;
                            hit_idx_next   = IW'(slot_reg);
                            if (mode_reg == sit_pkg::MODE_REMOVE) begin
                                psel_next = sit_pkg::PS_BYPASS;
                            end
                        end
                    end
                    sit_pkg::MODE_SPLIT: begin
                        if (st_reg == sit_pkg::ST_OK && slot_hit) begin
                            if (!(off_reg > tail_start && {1'b0, off_reg} < t_end)) begin
                                st_next = sit_pkg::ST_BAD_SPLIT;
                            end else if (full) begin
                                st_next = sit_pkg::ST_FULL;
                            end else begin
                                b_len_next     = off_reg - tail_start;
                                new_start_next = off_reg;
                                new_len_next   = 32'(t_end - {1'b0, off_reg});
                                new_tag_next   = tail_tag;
                                hit_start_next = off_reg;
                                hit_len_next   = 32'(t_end - {1'b0, off_reg});
                                hit_tag_next   = tail_tag;
                                hit_idx_next   = IW'(slot_reg) + IW'(1);
                                ins_arm_next   = 1'b1;
                                ins_step_next  = step_reg + SW'(2);
                            end
                        end
                    end
                    sit_pkg::MODE_FIND, sit_pkg::MODE_RANGE: begin
                        if (held && tail_start <= off_reg) begin
                            pa_valid_next  = 1'b1;
                            pa_end_next    = t_end;
                            hit_start_next = tail_start;
                            hit_len_next   = tail_length;
                            hit_tag_next   = tail_tag;
                            hit_idx_next   = IW'(step_reg);
                        end
                        if (held && {1'b0, tail_start} <= lastpt_reg) begin
                            pb_valid_next = 1'b1;
                            pb_end_next   = t_end;
                        end
                        if (held && (step_reg + SW'(1)) == count_reg) begin
                            last_end_next = t_end;
                        end
                        if (step_reg != '0 && held && tail_start > off_reg &&
                            {1'b0, tail_start} <= lastpt_reg &&
                            b_end != {1'b0, tail_start}) begin
                            brk_next = 1'b1;
                        end
                    end
                    default: st_next = st_reg;
                endcase
            end

            sit_pkg::FSM_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    if (fin_st == sit_pkg::ST_OK) begin
                        if (mode_reg == sit_pkg::MODE_ADD || mode_reg == sit_pkg::MODE_SPLIT) begin
                            count_next = count_reg + SW'(1);
                        end else if (mode_reg == sit_pkg::MODE_REMOVE) begin
                            count_next = count_reg - SW'(1);
                        end
                    end
                    m_tdata_next = {3'b000,
                                    9'(count_next),
                                    fin_entry ? 32'(hit_tag_reg) : 32'd0,
                                    fin_entry ? hit_len_reg : 32'd0,
                                    fin_entry ? hit_start_reg : 32'd0,
                                    fin_entry ? 8'(hit_idx_reg) : 8'd0,
                                    fin_st};
                end
            end

            default: step_next = step_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sit_pkg::FSM_IDLE;
            psel_reg     <= sit_pkg::PS_DELAY1;
            count_reg    <= '0;
            step_reg     <= '0;
            ins_arm_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            psel_reg     <= psel_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            ins_arm_reg  <= ins_arm_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        slot_reg      <= slot_next;
        end_reg       <= end_next;
        lastpt_reg    <= lastpt_next;
        st_reg        <= st_next;
        found_reg     <= found_next;
        ins_step_reg  <= ins_step_next;
        new_start_reg <= new_start_next;
        new_len_reg   <= new_len_next;
        new_tag_reg   <= new_tag_next;
        b_start_reg   <= b_start_next;
        b_len_reg     <= b_len_next;
        b_tag_reg     <= b_tag_next;
        b2_start_reg  <= b2_start_next;
        b2_len_reg    <= b2_len_next;
        b2_tag_reg    <= b2_tag_next;
        hit_start_reg <= hit_start_next;
        hit_len_reg   <= hit_len_next;
        hit_tag_reg   <= hit_tag_next;
        hit_idx_reg   <= hit_idx_next;
        pa_valid_reg  <= pa_valid_next;
        pa_end_reg    <= pa_end_next;
        pb_valid_reg  <= pb_valid_next;
        pb_end_reg    <= pb_end_next;
        last_end_reg  <= last_end_next;
        brk_reg       <= brk_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_W)
        else $error("entry count exceeds capacity");

    a_bypass_only_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sit_pkg::FSM_SCAN && psel_reg == sit_pkg::PS_BYPASS)
        |-> mode_reg == sit_pkg::MODE_REMOVE)
        else $error("chain closed up outside a remove");

    a_delay2_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sit_pkg::FSM_SCAN && psel_reg == sit_pkg::PS_DELAY2)
        |-> (mode_reg == sit_pkg::MODE_ADD || mode_reg == sit_pkg::MODE_SPLIT))
        else $error("chain opened up outside an add or split");

    a_count_only_at_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sit_pkg::FSM_DONE) |=> $stable(count_reg))
        else $error("entry count changed away from reply");

endmodule

// ===== src/sorted_interval_table.sv =====
// Top level of the sorted interval table: cell chain plus request controller.
//
// Channel  Dir  Fields (lowest bit up)
// s_       in   tdata: mode[2:0] offset[34:3] length[66:35] slot[74:67] tag[106:75]
// m_       out  tdata: status[3:0] found_slot[11:4] entry_start[43:12]
//                      entry_length[75:44] entry_tag[107:76] entry_count[116:108]
//
// Each request is accepted, then the cell chain is rotated once through the
// controller, then the reply is formed.
// A reply sits in the output register until taken; the next request is accepted
// meanwhile, but its reply waits until the earlier one has left.
// Reset clears the entry count, controller state and output valid; the chain contents are not cleared.
`timescale 1ns / 1ps

module sorted_interval_table #(
    parameter int CAPACITY  = sit_pkg::SIT_CAPACITY,
    parameter int TAG_WIDTH = sit_pkg::SIT_TAG_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, offset, length, slot, tag, then five zero bits
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, found_slot, entry_start, entry_length, entry_tag, entry_count, three zero bits
    output logic [119:0] m_tdata
);

    logic                 shift_en;
    logic [31:0]          chain_start  [CAPACITY+1];
    logic [31:0]          chain_length [CAPACITY+1];
    logic [TAG_WIDTH-1:0] chain_tag    [CAPACITY+1];

    sit_ctrl #(
        .CAPACITY  (CAPACITY),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .shift_en    (shift_en),
        .push_start  (chain_start[0]),
        .push_length (chain_length[0]),
        .push_tag    (chain_tag[0]),
        .tail_start  (chain_start[CAPACITY]),
        .tail_length (chain_length[CAPACITY]),
        .tail_tag    (chain_tag[CAPACITY])
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        sit_cell #(
            .TAG_WIDTH (TAG_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .din_start  (chain_start[k]),
            .din_length (chain_length[k]),
            .din_tag    (chain_tag[k]),
            .start_reg  (chain_start[k+1]),
            .length_reg (chain_length[k+1]),
            .tag_reg    (chain_tag[k+1])
        );
    end

endmodule
